[hdl/fan_tacho_median_rpm_top_assert.svh]
// Assertion macros for the fan tachometer top module.
`ifndef FAN_TACHO_MEDIAN_RPM_TOP_ASSERT_SVH
`define FAN_TACHO_MEDIAN_RPM_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FTM_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FTM_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hdl/ftm_pkg.sv]
package ftm_pkg;
    localparam int FAN_COUNT_DEF    = 4;
    localparam int MEDIAN_DEPTH_DEF = 5;
    localparam int SPEED_W          = 16;
    localparam int WIN_W            = 16;
    localparam int PPR_W            = 4;
    localparam int PROD_W           = 32;
    localparam int QUO_W            = 32;
    localparam logic [15:0] SPEED_MAX = 16'hFFFF;
    localparam logic [15:0] RPM_SCALE = 16'd60000;
    localparam logic [15:0] WIN_RESET = 16'd1000;
    localparam logic [3:0]  PPR_RESET = 4'd2;
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_PPR    = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN, ST_DIV1, ST_DIV2, ST_STORE, ST_SORT, ST_OUT
    } ftm_state_t;

    // Control group from the sequencer to every lane.
    typedef struct packed {
        logic start_div1;
        logic start_div2;
        logic store;
        logic sort_step;
        logic sort_odd;
    } ftm_lane_ctl_t;
endpackage

[hdl/ftm_divider.sv]
module ftm_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [ftm_pkg::QUO_W-1:0] dividend,
    input  logic [ftm_pkg::WIN_W-1:0] divisor,
    output logic                    busy,
    output logic [ftm_pkg::QUO_W-1:0] quotient
);
    import ftm_pkg::*;

    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [WIN_W:0]   rem_reg, rem_next;
    logic [WIN_W-1:0] dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WIN_W:0]   trial;

    // One quotient bit per cycle, restoring; hold the divisor taken at start.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[WIN_W-1:0], quo_reg[QUO_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

[hdl/ftm_lane.sv]
module ftm_lane #(
    parameter int MEDIAN_DEPTH = ftm_pkg::MEDIAN_DEPTH_DEF,
    parameter int SLOT_W       = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         count_en,
    input  logic                         edge_in,
    input  logic                         clear,
    input  ftm_pkg::ftm_lane_ctl_t       ctl,
    input  logic [ftm_pkg::WIN_W-1:0]    win,
    input  logic [ftm_pkg::PPR_W-1:0]    ppr,
    input  logic [SLOT_W-1:0]            slot,
    input  logic [SLOT_W:0]              fill,
    output logic                         busy,
    output logic [ftm_pkg::SPEED_W-1:0]  median
);
    import ftm_pkg::*;

    logic [SPEED_W-1:0] cnt_reg;
    logic [SPEED_W-1:0] cnt_inc;
    logic [SPEED_W-1:0] ring_reg [MEDIAN_DEPTH];
    logic [SPEED_W-1:0] srt_reg  [MEDIAN_DEPTH];
    logic [QUO_W-1:0]   div_a;
    logic [WIN_W-1:0]   div_b;
    logic [QUO_W-1:0]   quo;
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W:0]   mid_sum;
    logic [SLOT_W:0]    half;

    // Count including the current request, so a closing edge still belongs to the window.
    assign cnt_inc = (count_en && edge_in && cnt_reg != SPEED_MAX) ?
                     cnt_reg + 16'd1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else if (clear) cnt_reg <= '0;
        else cnt_reg <= cnt_inc;
    end

    // Share one divider: first by the window, then by pulses per revolution.
    assign div_a = ctl.start_div1 ? (QUO_W'(cnt_inc) * QUO_W'(RPM_SCALE)) : quo;
    assign div_b = ctl.start_div1 ? win : WIN_W'(ppr);

    ftm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.start_div1 | ctl.start_div2),
        .dividend(div_a), .divisor(div_b), .busy(busy), .quotient(quo)
    );

    assign speed = (quo > QUO_W'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];

    // Store the new sample, copy ring, then odd-even transposition sort.
    always_ff @(posedge aclk) begin
        if (ctl.store) begin
            for (int i = 0; i < MEDIAN_DEPTH; i++) begin
                if (SLOT_W'(i) == slot) begin
                    ring_reg[i] <= speed;
                    srt_reg[i]  <= speed;
                end else begin
                    srt_reg[i]  <= (SLOT_W+1)'(i) < fill ? ring_reg[i] : SPEED_MAX;
                end
            end
        end else if (ctl.sort_step) begin
            for (int i = 0; i + 1 < MEDIAN_DEPTH; i++) begin
                if ((i % 2 == 1) == ctl.sort_odd && srt_reg[i] > srt_reg[i+1]) begin
                    srt_reg[i]   <= srt_reg[i+1];
                    srt_reg[i+1] <= srt_reg[i];
                end
            end
        end
    end

    // Fill here counts the new sample already.
    assign half    = fill >> 1;
    always_comb begin
        mid_sum = '0;
        median  = '0;
        for (int i = 0; i < MEDIAN_DEPTH; i++) begin
            if ((SLOT_W+1)'(i) == half) begin
                if (fill[0]) begin
                    median = srt_reg[i];
                end else begin
                    mid_sum = {1'b0, srt_reg[i]} + {1'b0, srt_reg[(i+MEDIAN_DEPTH-1)%MEDIAN_DEPTH]};
                    median  = mid_sum[SPEED_W:1];
                end
            end
        end
    end
endmodule

[hdl/fan_tacho_median_rpm_top.sv]
// Four-fan tachometer with a per-fan running median.
// Input channel s_*: one request per clock at most; s_tdata holds ms_tick and
// one falling-edge flag per fan. Edges and ticks are counted in saturating
// 16-bit counters. When elapsed milliseconds reach window_ms the window
// closes (the closing request still counts), and each fan's rpm sample is
// computed, pushed into its ring of the last MEDIAN_DEPTH samples, and the
// ring median is sent as one request on m_*.
// An ordinary request is accepted and s_tready stays high.
// A closing request puts the result on m_* after these steps in order:
// the serial divider of each lane (count*60000/window, then /pulses),
// the store state, MEDIAN_DEPTH sort steps and the output state;
// the four lanes run side by side and s_tready stays low meanwhile.
// Config channel cfg_*: index 0 window_ms, 1 pulses_per_rev; write when idle.
// Reset (aresetn low, synchronous) clears counters, fill and slot, and
// loads the register defaults; the sample rings need no clearing.
// A stalled m_tready holds the result in the output register and keeps
// s_tready low until it is taken.
module fan_tacho_median_rpm_top #(
    parameter int MEDIAN_DEPTH = ftm_pkg::MEDIAN_DEPTH_DEF,
    parameter int FAN_COUNT    = ftm_pkg::FAN_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ms_tick, edge_fan0..edge_fan3, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // speed_fan0..speed_fan3, 16 bits each
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ftm_pkg::*;
    `include "fan_tacho_median_rpm_top_assert.svh"

    localparam int SLOT_W = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;

    ftm_state_t         state_reg, state_next;
    logic [WIN_W-1:0]   win_reg;
    logic [PPR_W-1:0]   ppr_reg;
    logic [WIN_W-1:0]   elapsed_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W:0]    fill_reg;
    logic [SLOT_W:0]    sort_cnt_reg, sort_cnt_next;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    ftm_lane_ctl_t      ctl;
    logic [FAN_COUNT-1:0] lane_busy;
    logic [SPEED_W-1:0] lane_med [FAN_COUNT];
    logic [WIN_W-1:0]   win_eff;
    logic [PPR_W-1:0]   ppr_eff;
    logic [WIN_W-1:0]   elapsed_inc;
    logic               accept, closing;

    assign cfg_ready = 1'b1;
    assign win_eff   = (win_reg == '0) ? WIN_W'(1) : win_reg;
    assign ppr_eff   = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
    assign s_tready  = (state_reg == ST_RUN) && !out_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign elapsed_inc = (s_tdata[0] && elapsed_reg != SPEED_MAX) ?
                         elapsed_reg + 16'd1 : elapsed_reg;
    assign closing   = accept && (elapsed_inc >= win_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
            ppr_reg <= PPR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW: win_reg <= cfg_data;
                CFG_PPR:    ppr_reg <= cfg_data[PPR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequencer for the window close.
    always_comb begin
        state_next    = state_reg;
        sort_cnt_next = sort_cnt_reg;
        ctl           = '0;
        unique case (state_reg)
            ST_RUN: if (closing) begin
                ctl.start_div1 = 1'b1;
                state_next     = ST_DIV1;
            end
            ST_DIV1: if (lane_busy == '0) begin
                ctl.start_div2 = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2: if (lane_busy == '0) state_next = ST_STORE;
            ST_STORE: begin
                ctl.store     = 1'b1;
                sort_cnt_next = '0;
                state_next    = ST_SORT;
            end
            ST_SORT: begin
                ctl.sort_step = 1'b1;
                ctl.sort_odd  = sort_cnt_reg[0];
                sort_cnt_next = sort_cnt_reg + 1'b1;
                if (sort_cnt_reg == (SLOT_W+1)'(MEDIAN_DEPTH - 1)) state_next = ST_OUT;
            end
            ST_OUT:  state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            sort_cnt_reg  <= '0;
            elapsed_reg   <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sort_cnt_reg <= sort_cnt_next;
            if (closing) elapsed_reg <= '0;
            else if (accept) elapsed_reg <= elapsed_inc;
            if (ctl.store) begin
                slot_reg <= (slot_reg == SLOT_W'(MEDIAN_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg != (SLOT_W+1)'(MEDIAN_DEPTH)) fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == ST_OUT) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // Merge the lane medians into the result word.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT) begin
            for (int f = 0; f < FAN_COUNT; f++) out_data_reg[f*16 +: 16] <= lane_med[f];
        end
    end

    // Fill seen by lanes during sort and output already includes the new sample.
    genvar g;
    for (g = 0; g < FAN_COUNT; g++) begin : g_lane
        ftm_lane #(.MEDIAN_DEPTH(MEDIAN_DEPTH), .SLOT_W(SLOT_W)) u_lane (
            .aclk(aclk), .aresetn(aresetn),
            .count_en(accept), .edge_in(s_tdata[1+g]), .clear(state_reg == ST_STORE),
            .ctl(ctl), .win(win_eff), .ppr(ppr_eff),
            .slot(slot_reg), .fill(fill_reg),
            .busy(lane_busy[g]), .median(lane_med[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `FTM_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_RUN, !s_tready, "accept while busy")
    `FTM_ASSERT_NEXT(a_close_starts, aclk, aresetn, closing, state_reg == ST_DIV1, "close lost")
    `FTM_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= (SLOT_W+1)'(MEDIAN_DEPTH), "fill overrun")
endmodule
